// File: src/ebf_pkg.sv
// Shared types and constants for the EASY backfill admission unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ebf_pkg;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned MACH_W = 11;
  localparam int unsigned STAT_W = 2;

  localparam logic [MACH_W-1:0] MACH_MAX   = '1;
  localparam logic [MACH_W-1:0] MACH_RESET = 11'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_SUBMIT   = 2'd0,
    CMD_PRIORITY = 2'd1,
    CMD_BACKFILL = 2'd2,
    CMD_FINISH   = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NOTFOUND = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_PRI_WALK,
    ST_INS_FIND,
    ST_INS_SHIFT,
    ST_INS_PUT,
    ST_FIN_WALK,
    ST_FIN_SHIFT,
    ST_RESP
  } state_e;

endpackage
`default_nettype wire

// File: src/ebf_if.sv
// Valid/ready channel interfaces for command items and result items.
// Depends on ebf_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface ebf_in_if #(parameter int unsigned TIME_BITS = 48);
  logic                       valid;
  logic                       ready;
  logic [ebf_pkg::CMD_W-1:0]  command;
  logic [ebf_pkg::TAG_W-1:0]  job_tag;
  logic [ebf_pkg::MACH_W-1:0] requested;
  logic [TIME_BITS-1:0]       duration;
  logic [TIME_BITS-1:0]       now;
  logic                       walltime_given;

  modport source (output valid, command, job_tag, requested, duration, now, walltime_given,
                  input ready);
  modport sink   (input valid, command, job_tag, requested, duration, now, walltime_given,
                  output ready);
endinterface

interface ebf_out_if #(parameter int unsigned TIME_BITS = 48);
  logic                       valid;
  logic                       ready;
  logic                       can_run;
  logic [TIME_BITS-1:0]       shadow_start;
  logic [ebf_pkg::MACH_W-1:0] extra_machines;
  logic [ebf_pkg::MACH_W-1:0] free_machines;
  logic [ebf_pkg::STAT_W-1:0] status;

  modport source (output valid, can_run, shadow_start, extra_machines, free_machines, status,
                  input ready);
  modport sink   (input valid, can_run, shadow_start, extra_machines, free_machines, status,
                  output ready);
endinterface
`default_nettype wire

// File: src/easy_backfill_admission_unit.sv
// Top level of the EASY backfill admission unit: sequencer, reservation state, job table.
// Depends on ebf_pkg, ebf_if and ebf_ram.
`timescale 1ns / 1ps
`default_nettype none
// One command is processed at a time; in_if.ready is high only while the unit is idle.
// Submit and a check that does not touch the table go from the dispatch state straight to the response state.
// Walks over the running-job table (sorted by finish time, one RAM entry per cycle) serve the
// reservation search, the finish lookup, the sorted insert and the finish with removal;
// their length grows with N, the number of running jobs (at most MAX_RUNNING). Writing
// total_machines recomputes the free count at once from a running sum of held machines.
module easy_backfill_admission_unit #(
  parameter int unsigned MAX_RUNNING = 64,
  parameter int unsigned TIME_BITS   = 48
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_we_i,
  input  wire  [ebf_pkg::MACH_W-1:0]  cfg_wdata_i,
  ebf_in_if.sink                      in_if,
  ebf_out_if.source                   out_if
);
  localparam int unsigned MW = ebf_pkg::MACH_W;
  localparam int unsigned TW = ebf_pkg::TAG_W;
  localparam int unsigned AW = $clog2(MAX_RUNNING);
  localparam int unsigned CW = $clog2(MAX_RUNNING + 1);
  localparam int unsigned HW = MW + CW;
  localparam int unsigned EW = TW + MW + TIME_BITS;
  localparam logic [CW-1:0] CNT_FULL = CW'(MAX_RUNNING);

  ebf_pkg::state_e state_q, state_d;

  logic [ebf_pkg::CMD_W-1:0] cmd_q, cmd_d;
  logic [TW-1:0]        tag_q, tag_d;
  logic [MW-1:0]        req_q, req_d;
  logic [TIME_BITS-1:0] fin_q, fin_d;
  logic                 wall_q, wall_d;
  logic [MW-1:0]        total_q, total_d;
  logic [CW-1:0]        count_q, count_d;
  logic [MW-1:0]        free_q, free_d;
  logic [HW-1:0]        held_q, held_d;
  logic [TW-1:0]        rtag_q, rtag_d;
  logic [MW-1:0]        rmach_q, rmach_d;
  logic [TIME_BITS-1:0] shadow_q, shadow_d;
  logic [MW-1:0]        extra_q, extra_d;
  logic                 rvalid_q, rvalid_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic [CW-1:0]        pos_q, pos_d;
  logic [HW-1:0]        cnt_q, cnt_d;
  logic [MW-1:0]        imach_q, imach_d;
  logic                 long_q, long_d;
  logic                 can_q, can_d;
  logic [ebf_pkg::STAT_W-1:0] stat_q, stat_d;
  logic                 ovalid_q, ovalid_d;
  logic                 ocan_q, ocan_d;
  logic [TIME_BITS-1:0] oshadow_q, oshadow_d;
  logic [MW-1:0]        oextra_q, oextra_d;
  logic [MW-1:0]        ofree_q, ofree_d;
  logic [ebf_pkg::STAT_W-1:0] ostat_q, ostat_d;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [EW-1:0]   ram_wdata, ram_rdata;

  logic [TW-1:0]        rd_tag;
  logic [MW-1:0]        rd_mach;
  logic [TIME_BITS-1:0] rd_fin;
  logic [TIME_BITS:0]   fin_sum;
  logic [CW-1:0]        idx_p1, idx_p2, idx_m1, idx_m2, cnt_m1;
  logic                 last, full, empty;
  logic [MW-1:0]        rm_eff, bf_lim;
  logic                 pri_fits, short_job, bf_fits;
  logic [HW-1:0]        cnt_sum, ex_diff;
  logic                 pri_hit, fin_hit, ins_gt;
  logic [MW:0]          free_add;
  logic                 out_go, resp_go;

  ebf_ram #(.WIDTH(EW), .DEPTH(MAX_RUNNING)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign {rd_tag, rd_mach, rd_fin} = ram_rdata;

  assign fin_sum   = {1'b0, in_if.now} + {1'b0, in_if.duration};
  assign idx_p1    = idx_q + CW'(1);
  assign idx_p2    = idx_q + CW'(2);
  assign idx_m1    = idx_q - CW'(1);
  assign idx_m2    = idx_q - CW'(2);
  assign cnt_m1    = count_q - CW'(1);
  assign last      = (idx_p1 == count_q);
  assign full      = (count_q == CNT_FULL);
  assign empty     = (count_q == '0);
  assign rm_eff    = (rvalid_q && tag_q == rtag_q) ? rmach_q : req_q;
  assign pri_fits  = (rm_eff <= free_q);
  assign short_job = (fin_q <= shadow_q);
  assign bf_lim    = (free_q < extra_q) ? free_q : extra_q;
  assign bf_fits   = short_job ? (req_q <= free_q) : (req_q <= bf_lim);
  assign cnt_sum   = cnt_q + HW'(rd_mach);
  assign pri_hit   = (cnt_sum >= HW'(rmach_q));
  assign ex_diff   = cnt_sum - HW'(rmach_q);
  assign fin_hit   = (rd_tag == tag_q);
  assign ins_gt    = (rd_fin > fin_q);
  assign free_add  = {1'b0, free_q} + {1'b0, rd_mach};
  assign out_go    = ovalid_q && out_if.ready;
  assign resp_go   = !ovalid_q || out_if.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ebf_pkg::ST_IDLE: begin
        if (in_if.valid) state_d = ebf_pkg::ST_DISPATCH;
      end
      ebf_pkg::ST_DISPATCH: begin
        unique case (ebf_pkg::cmd_e'(cmd_q))
          ebf_pkg::CMD_SUBMIT: state_d = ebf_pkg::ST_RESP;
          ebf_pkg::CMD_PRIORITY: begin
            if (pri_fits) begin
              state_d = full ? ebf_pkg::ST_RESP :
                        empty ? ebf_pkg::ST_INS_PUT : ebf_pkg::ST_INS_FIND;
            end else begin
              state_d = empty ? ebf_pkg::ST_RESP : ebf_pkg::ST_PRI_WALK;
            end
          end
          ebf_pkg::CMD_BACKFILL: begin
            if (bf_fits) begin
              state_d = full ? ebf_pkg::ST_RESP :
                        empty ? ebf_pkg::ST_INS_PUT : ebf_pkg::ST_INS_FIND;
            end else begin
              state_d = ebf_pkg::ST_RESP;
            end
          end
          ebf_pkg::CMD_FINISH: state_d = empty ? ebf_pkg::ST_RESP : ebf_pkg::ST_FIN_WALK;
          default: state_d = ebf_pkg::ST_RESP;
        endcase
      end
      ebf_pkg::ST_INS_FIND: begin
        if (ins_gt) state_d = ebf_pkg::ST_INS_SHIFT;
        else if (last) state_d = ebf_pkg::ST_INS_PUT;
      end
      ebf_pkg::ST_INS_SHIFT: begin
        if (idx_m1 == pos_q) state_d = ebf_pkg::ST_INS_PUT;
      end
      ebf_pkg::ST_INS_PUT: state_d = ebf_pkg::ST_RESP;
      ebf_pkg::ST_PRI_WALK: begin
        if (pri_hit || last) state_d = ebf_pkg::ST_RESP;
      end
      ebf_pkg::ST_FIN_WALK: begin
        if (fin_hit) state_d = last ? ebf_pkg::ST_RESP : ebf_pkg::ST_FIN_SHIFT;
        else if (last) state_d = ebf_pkg::ST_RESP;
      end
      ebf_pkg::ST_FIN_SHIFT: begin
        if (idx_p2 == count_q) state_d = ebf_pkg::ST_RESP;
      end
      ebf_pkg::ST_RESP: begin
        if (resp_go) state_d = ebf_pkg::ST_IDLE;
      end
      default: state_d = ebf_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_d = cmd_q;  tag_d = tag_q;  req_d = req_q;  fin_d = fin_q;  wall_d = wall_q;
    total_d = total_q;  count_d = count_q;  free_d = free_q;  held_d = held_q;
    rtag_d = rtag_q;  rmach_d = rmach_q;  shadow_d = shadow_q;  extra_d = extra_q;
    rvalid_d = rvalid_q;  idx_d = idx_q;  pos_d = pos_q;  cnt_d = cnt_q;
    imach_d = imach_q;  long_d = long_q;  can_d = can_q;  stat_d = stat_q;
    ovalid_d = out_go ? 1'b0 : ovalid_q;
    ocan_d = ocan_q;  oshadow_d = oshadow_q;  oextra_d = oextra_q;
    ofree_d = ofree_q;  ostat_d = ostat_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = '0;
    in_if.ready = 1'b0;

    unique case (state_q)
      ebf_pkg::ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          cmd_d  = in_if.command;
          tag_d  = in_if.job_tag;
          req_d  = in_if.requested;
          wall_d = in_if.walltime_given;
          fin_d  = fin_sum[TIME_BITS] ? '1 : fin_sum[TIME_BITS-1:0];
        end
      end
      ebf_pkg::ST_DISPATCH: begin
        can_d  = 1'b0;
        stat_d = ebf_pkg::STAT_OK;
        idx_d  = '0;
        pos_d  = '0;
        unique case (ebf_pkg::cmd_e'(cmd_q))
          ebf_pkg::CMD_SUBMIT: can_d = wall_q && (req_q <= total_q);
          ebf_pkg::CMD_PRIORITY: begin
            rvalid_d = 1'b1;
            rtag_d   = tag_q;
            rmach_d  = rm_eff;
            if (pri_fits) begin
              imach_d = rm_eff;
              long_d  = 1'b0;
              if (full) stat_d = ebf_pkg::STAT_FULL;
            end else begin
              cnt_d = HW'(free_q);
            end
          end
          ebf_pkg::CMD_BACKFILL: begin
            imach_d = req_q;
            long_d  = !short_job;
            if (bf_fits && full) stat_d = ebf_pkg::STAT_FULL;
          end
          ebf_pkg::CMD_FINISH: begin
            if (empty) stat_d = ebf_pkg::STAT_NOTFOUND;
          end
          default: can_d = 1'b0;
        endcase
      end
      ebf_pkg::ST_INS_FIND: begin
        if (ins_gt) begin
          pos_d     = idx_q;
          idx_d     = count_q;
          ram_raddr = cnt_m1[AW-1:0];
        end else if (last) begin
          pos_d = count_q;
        end else begin
          idx_d     = idx_p1;
          ram_raddr = idx_p1[AW-1:0];
        end
      end
      ebf_pkg::ST_INS_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        if (idx_m1 != pos_q) begin
          idx_d     = idx_m1;
          ram_raddr = idx_m2[AW-1:0];
        end
      end
      ebf_pkg::ST_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[AW-1:0];
        ram_wdata = {tag_q, imach_q, fin_q};
        count_d   = count_q + CW'(1);
        held_d    = held_q + HW'(imach_q);
        free_d    = (free_q >= imach_q) ? free_q - imach_q : '0;
        if (long_q) extra_d = (extra_q >= imach_q) ? extra_q - imach_q : '0;
        can_d     = 1'b1;
      end
      ebf_pkg::ST_PRI_WALK: begin
        if (pri_hit) begin
          shadow_d = rd_fin;
          extra_d  = (ex_diff > HW'(ebf_pkg::MACH_MAX)) ? ebf_pkg::MACH_MAX : ex_diff[MW-1:0];
        end else if (!last) begin
          cnt_d     = cnt_sum;
          idx_d     = idx_p1;
          ram_raddr = idx_p1[AW-1:0];
        end
      end
      ebf_pkg::ST_FIN_WALK: begin
        if (fin_hit) begin
          free_d = free_add[MW] ? ebf_pkg::MACH_MAX : free_add[MW-1:0];
          held_d = held_q - HW'(rd_mach);
          if (last) begin
            count_d = cnt_m1;
            can_d   = 1'b1;
          end else begin
            ram_raddr = idx_p1[AW-1:0];
          end
        end else if (last) begin
          stat_d = ebf_pkg::STAT_NOTFOUND;
        end else begin
          idx_d     = idx_p1;
          ram_raddr = idx_p1[AW-1:0];
        end
      end
      ebf_pkg::ST_FIN_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        if (idx_p2 == count_q) begin
          count_d = cnt_m1;
          can_d   = 1'b1;
        end else begin
          idx_d     = idx_p1;
          ram_raddr = idx_p2[AW-1:0];
        end
      end
      ebf_pkg::ST_RESP: begin
        if (resp_go) begin
          ovalid_d  = 1'b1;
          ocan_d    = can_q;
          oshadow_d = shadow_q;
          oextra_d  = extra_q;
          ofree_d   = free_q;
          ostat_d   = stat_q;
        end
      end
      default: in_if.ready = 1'b0;
    endcase

    if (cfg_we_i) begin
      total_d = cfg_wdata_i;
      free_d  = (HW'(cfg_wdata_i) > held_q) ? MW'(HW'(cfg_wdata_i) - held_q) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ebf_pkg::ST_IDLE;
      total_q  <= ebf_pkg::MACH_RESET;
      count_q  <= '0;
      free_q   <= ebf_pkg::MACH_RESET;
      held_q   <= '0;
      rtag_q   <= '0;
      rmach_q  <= '0;
      shadow_q <= '1;
      extra_q  <= '0;
      rvalid_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      total_q  <= total_d;
      count_q  <= count_d;
      free_q   <= free_d;
      held_q   <= held_d;
      rtag_q   <= rtag_d;
      rmach_q  <= rmach_d;
      shadow_q <= shadow_d;
      extra_q  <= extra_d;
      rvalid_q <= rvalid_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;   tag_q  <= tag_d;   req_q   <= req_d;   fin_q  <= fin_d;
    wall_q <= wall_d;  idx_q  <= idx_d;   pos_q   <= pos_d;   cnt_q  <= cnt_d;
    imach_q <= imach_d; long_q <= long_d; can_q   <= can_d;   stat_q <= stat_d;
    ocan_q <= ocan_d;  oshadow_q <= oshadow_d;  oextra_q <= oextra_d;
    ofree_q <= ofree_d; ostat_q <= ostat_d;
  end

  assign out_if.valid          = ovalid_q;
  assign out_if.can_run        = ocan_q;
  assign out_if.shadow_start   = oshadow_q;
  assign out_if.extra_machines = oextra_q;
  assign out_if.free_machines  = ofree_q;
  assign out_if.status         = ostat_q;
endmodule
`default_nettype wire

// File: src/ebf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ebf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: src/ebf_checker.sv
// Port-level assertions for the EASY backfill admission unit, bound to the top level.
// Depends on ebf_pkg and easy_backfill_admission_unit.
`timescale 1ns / 1ps
`default_nettype none
module ebf_checker (
  input wire                        clk_i,
  input wire                        rst_ni,
  input wire                        in_valid_i,
  input wire                        in_ready_i,
  input wire                        out_valid_i,
  input wire                        out_ready_i,
  input wire                        out_can_run_i,
  input wire [ebf_pkg::STAT_W-1:0]  out_status_i
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("new command taken while busy");

  a_can_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_can_run_i |-> out_status_i == ebf_pkg::STAT_OK)
    else $error("can_run with error status");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_status_i == ebf_pkg::STAT_OK || out_status_i == ebf_pkg::STAT_FULL ||
                    out_status_i == ebf_pkg::STAT_NOTFOUND)
    else $error("bad status code");
endmodule

bind easy_backfill_admission_unit ebf_checker u_ebf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_if.valid),
  .in_ready_i    (in_if.ready),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .out_can_run_i (out_if.can_run),
  .out_status_i  (out_if.status)
);
`default_nettype wire

// File: dv/ebf_checker.sv
// Scoreboard for the EASY backfill admission unit: mirrors the job table and reservation,
// predicts one result per command transfer and compares it with the output transfers.
// Depends on ebf_pkg and the ebf_in_if / ebf_out_if interfaces.
`timescale 1ns / 1ps
module ebf_scoreboard #(
  parameter int unsigned MAX_RUNNING = 64,
  parameter int unsigned TIME_BITS   = 48
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ebf_pkg::MACH_W-1:0] cfg_wdata_i,
  ebf_in_if                          in_mon,
  ebf_out_if                         out_mon,
  output int                         fail_count_o,
  output int                         pending_o,
  output int                         checked_o
);
  localparam logic [TIME_BITS-1:0] TMAX = '1;
  localparam int SAT = 2047;

  typedef struct packed {
    logic                          can_run;
    logic [TIME_BITS-1:0]          shadow;
    logic [ebf_pkg::MACH_W-1:0]    extra;
    logic [ebf_pkg::MACH_W-1:0]    free;
    logic [ebf_pkg::STAT_W-1:0]    status;
  } verdict_t;

  verdict_t                  verdict_q[$];
  logic [ebf_pkg::TAG_W-1:0] job_tag_r [MAX_RUNNING];
  int                        job_mach_r[MAX_RUNNING];
  logic [TIME_BITS-1:0]      job_end_r [MAX_RUNNING];
  int                        njobs, free_m, total_m, resv_mach, resv_extra;
  logic [ebf_pkg::TAG_W-1:0] resv_tag;
  logic [TIME_BITS-1:0]      resv_shadow;
  bit                        resv_seen;

  assign pending_o = verdict_q.size();

  function automatic logic [TIME_BITS-1:0] finish_at(logic [TIME_BITS-1:0] t0,
                                                     logic [TIME_BITS-1:0] d);
    logic [TIME_BITS:0] s;
    s = {1'b0, t0} + {1'b0, d};
    return s[TIME_BITS] ? TMAX : s[TIME_BITS-1:0];
  endfunction

  function automatic bit start_job(logic [ebf_pkg::TAG_W-1:0] tag, int m,
                                   logic [TIME_BITS-1:0] fin);
    int pos;
    if (njobs >= MAX_RUNNING) return 0;
    pos = njobs;
    for (int i = 0; i < njobs; i++)
      if (job_end_r[i] > fin) begin
        pos = i;
        break;
      end
    for (int i = njobs; i > pos; i--) begin
      job_tag_r[i]  = job_tag_r[i-1];
      job_mach_r[i] = job_mach_r[i-1];
      job_end_r[i]  = job_end_r[i-1];
    end
    job_tag_r[pos] = tag;
    job_mach_r[pos] = m;
    job_end_r[pos] = fin;
    njobs++;
    free_m = (free_m >= m) ? free_m - m : 0;
    return 1;
  endfunction

  function automatic verdict_t admit(ebf_pkg::cmd_e cmd, logic [ebf_pkg::TAG_W-1:0] tag,
                                     int req, logic [TIME_BITS-1:0] dur,
                                     logic [TIME_BITS-1:0] t0, logic wall);
    verdict_t v;
    logic [TIME_BITS-1:0] fin;
    int cnt, lim, found;
    bit short_job, fits;
    v = '0;
    v.status = ebf_pkg::STAT_OK;
    case (cmd)
      ebf_pkg::CMD_SUBMIT: begin
        v.can_run = wall && (req <= total_m);
      end
      ebf_pkg::CMD_PRIORITY: begin
        if (!resv_seen || tag != resv_tag) begin
          resv_seen = 1;
          resv_tag  = tag;
          resv_mach = req;
        end
        if (resv_mach <= free_m) begin
          if (start_job(tag, resv_mach, finish_at(t0, dur))) v.can_run = 1;
          else v.status = ebf_pkg::STAT_FULL;
        end else begin
          cnt = free_m;
          for (int i = 0; i < njobs; i++) begin
            cnt += job_mach_r[i];
            if (cnt >= resv_mach) begin
              resv_shadow = job_end_r[i];
              resv_extra  = (cnt - resv_mach > SAT) ? SAT : cnt - resv_mach;
              break;
            end
          end
        end
      end
      ebf_pkg::CMD_BACKFILL: begin
        fin = finish_at(t0, dur);
        short_job = fin <= resv_shadow;
        lim = short_job ? free_m : ((free_m < resv_extra) ? free_m : resv_extra);
        fits = req <= lim;
        if (fits) begin
          if (start_job(tag, req, fin)) begin
            v.can_run = 1;
            if (!short_job) resv_extra = (resv_extra >= req) ? resv_extra - req : 0;
          end else begin
            v.status = ebf_pkg::STAT_FULL;
          end
        end
      end
      default: begin
        found = -1;
        for (int i = 0; i < njobs; i++)
          if (job_tag_r[i] == tag) begin
            found = i;
            break;
          end
        if (found >= 0) begin
          free_m = (free_m + job_mach_r[found] > SAT) ? SAT : free_m + job_mach_r[found];
          for (int i = found; i + 1 < njobs; i++) begin
            job_tag_r[i]  = job_tag_r[i+1];
            job_mach_r[i] = job_mach_r[i+1];
            job_end_r[i]  = job_end_r[i+1];
          end
          njobs--;
          v.can_run = 1;
        end else begin
          v.status = ebf_pkg::STAT_NOTFOUND;
        end
      end
    endcase
    v.shadow = resv_shadow;
    v.extra  = resv_extra[ebf_pkg::MACH_W-1:0];
    v.free   = free_m[ebf_pkg::MACH_W-1:0];
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    int held;
    verdict_t got, want;
    if (!rst_ni) begin
      verdict_q.delete();
      njobs = 0;
      total_m = ebf_pkg::MACH_RESET;
      free_m = ebf_pkg::MACH_RESET;
      resv_tag = '0;
      resv_mach = 0;
      resv_shadow = TMAX;
      resv_extra = 0;
      resv_seen = 0;
      fail_count_o <= 0;
      checked_o <= 0;
    end else begin
      if (cfg_we_i) begin
        held = 0;
        total_m = cfg_wdata_i;
        for (int i = 0; i < njobs; i++) held += job_mach_r[i];
        free_m = (total_m > held) ? total_m - held : 0;
      end
      if (in_mon.valid && in_mon.ready) begin
        want = admit(ebf_pkg::cmd_e'(in_mon.command), in_mon.job_tag,
                     int'(in_mon.requested), in_mon.duration, in_mon.now,
                     in_mon.walltime_given);
        verdict_q.insert(verdict_q.size(), want);
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.can_run, out_mon.shadow_start, out_mon.extra_machines,
                out_mon.free_machines, out_mon.status};
        checked_o <= checked_o + 1;
        if (verdict_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected, actual %h", $realtime, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = verdict_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected can=%0d shadow=%h extra=%0d free=%0d st=%0d",
                     $realtime, want.can_run, want.shadow, want.extra, want.free,
                     want.status);
            $display("%0t:          actual   can=%0d shadow=%h extra=%0d free=%0d st=%0d",
                     $realtime, got.can_run, got.shadow, got.extra, got.free, got.status);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

// File: dv/tb_easy_backfill_admission_unit.sv
// Testbench top for the EASY backfill admission unit: clock, reset, command stimulus,
// result back-pressure, register writes and the final verdict. Depends on ebf_pkg,
// ebf_if, the unit under test and ebf_scoreboard.
`timescale 1ns / 1ps
module tb_easy_backfill_admission_unit;
  localparam int unsigned NRUN = 64;
  localparam int unsigned TB   = 48;
  localparam logic [TB-1:0] TMAX = '1;
  localparam int WATCHDOG = 20000;

  logic clk_i, rst_ni, cfg_we_i;
  logic [ebf_pkg::MACH_W-1:0] cfg_wdata_i;
  int fails, pending, checked, sent, idle_cycles, burst_left, cur_total;
  logic [TB-1:0] sim_now;
  logic [ebf_pkg::TAG_W-1:0] pri_tag;

  ebf_in_if  #(.TIME_BITS(TB)) cmd_if ();
  ebf_out_if #(.TIME_BITS(TB)) res_if ();

  easy_backfill_admission_unit #(.MAX_RUNNING(NRUN), .TIME_BITS(TB)) u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_if(cmd_if), .out_if(res_if)
  );

  ebf_scoreboard #(.MAX_RUNNING(NRUN), .TIME_BITS(TB)) u_chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_mon(cmd_if), .out_mon(res_if), .fail_count_o(fails), .pending_o(pending),
    .checked_o(checked)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cmd_if.valid = 0; cmd_if.command = ebf_pkg::CMD_SUBMIT; cmd_if.job_tag = '0;
    cmd_if.requested = '0; cmd_if.duration = '0; cmd_if.now = '0;
    cmd_if.walltime_given = 0;
    res_if.ready = 0; cfg_we_i = 0; cfg_wdata_i = '0;
    rst_ni = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
  end

  // receiver: random stall modes, one long hold-off early in the run
  initial begin
    int mode;
    @(posedge rst_ni);
    repeat (2000) begin
      @(posedge clk_i);
      res_if.ready <= ($urandom_range(0, 3) != 0);
    end
    @(posedge clk_i);
    res_if.ready <= 0;
    repeat (3000) @(posedge clk_i);
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(16, 128)) begin
        @(posedge clk_i);
        case (mode)
          0: res_if.ready <= 1;
          1: res_if.ready <= $urandom_range(0, 1);
          default: res_if.ready <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  // no-progress watchdog
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG);
        $display("tb_easy_backfill_admission_unit: FAIL");
        $finish;
      end
    end
  end

  task automatic xfer(ebf_pkg::cmd_e cmd, logic [ebf_pkg::TAG_W-1:0] tag, int req,
                      logic [TB-1:0] dur, logic [TB-1:0] t0, logic wall);
    cmd_if.valid <= 1;
    cmd_if.command <= cmd;
    cmd_if.job_tag <= tag;
    cmd_if.requested <= req[ebf_pkg::MACH_W-1:0];
    cmd_if.duration <= dur;
    cmd_if.now <= t0;
    cmd_if.walltime_given <= wall;
    do @(posedge clk_i); while (!cmd_if.ready);
    sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        cmd_if.valid <= 0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  endtask

  task automatic set_total(int val);
    cmd_if.valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2 * NRUN + 8) @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= val[ebf_pkg::MACH_W-1:0];
    cur_total = val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic random_phase(int count, int fill);
    ebf_pkg::cmd_e cmd;
    int r, req;
    logic [TB-1:0] dur;
    logic [ebf_pkg::TAG_W-1:0] tag;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (fill) cmd = (r < 75) ? ebf_pkg::CMD_BACKFILL :
                      (r < 85) ? ebf_pkg::CMD_PRIORITY : ebf_pkg::CMD_FINISH;
      else cmd = (r < 15) ? ebf_pkg::CMD_SUBMIT : (r < 40) ? ebf_pkg::CMD_PRIORITY :
                 (r < 70) ? ebf_pkg::CMD_BACKFILL : ebf_pkg::CMD_FINISH;
      tag = ($urandom_range(0, 19) == 0) ? ebf_pkg::TAG_W'($urandom) :
            ebf_pkg::TAG_W'($urandom_range(0, 15));
      if (cmd == ebf_pkg::CMD_PRIORITY && $urandom_range(0, 2) != 0) tag = pri_tag;
      if (cmd == ebf_pkg::CMD_PRIORITY) pri_tag = tag;
      r = $urandom_range(0, 19);
      req = fill ? $urandom_range(0, 1) :
            (r == 0) ? 1024 : (r == 1) ? 0 : $urandom_range(0, cur_total / 2 + 1);
      r = $urandom_range(0, 29);
      dur = (r == 0) ? TMAX : (r == 1) ? '0 : (r == 2) ? TB'({$urandom, $urandom}) :
            TB'($urandom_range(1, 600));
      sim_now = ($urandom_range(0, 99) == 0) ? TB'({$urandom, $urandom}) :
                sim_now + TB'($urandom_range(0, 40));
      xfer(cmd, tag, req, dur, sim_now, $urandom_range(0, 5) != 0);
    end
  endtask

  initial begin
    sent = 0; burst_left = 4; cur_total = ebf_pkg::MACH_RESET; sim_now = '0; pri_tag = '0;
    @(posedge rst_ni);
    @(posedge clk_i);
    // directed: submit screening, reservation, backfill, finish corner cases
    xfer(ebf_pkg::CMD_SUBMIT,   16'h0000,   64, 48'd10, 48'd0, 1);
    xfer(ebf_pkg::CMD_SUBMIT,   16'hffff,   65, 48'd10, 48'd0, 1);
    xfer(ebf_pkg::CMD_SUBMIT,   16'h0001,    0, 48'd10, 48'd0, 0);
    xfer(ebf_pkg::CMD_SUBMIT,   16'h0002, 1024, TMAX,  TMAX,  1);
    xfer(ebf_pkg::CMD_FINISH,   16'h1234,    0, 48'd0, 48'd0, 0);
    xfer(ebf_pkg::CMD_PRIORITY, 16'h0010,  100, 48'd5, 48'd0, 1);
    xfer(ebf_pkg::CMD_BACKFILL, 16'h0020,   30, 48'd100, 48'd0, 1);
    xfer(ebf_pkg::CMD_BACKFILL, 16'h0021,   30, 48'd50, 48'd0, 1);
    xfer(ebf_pkg::CMD_BACKFILL, 16'h0021,    4, 48'd50, 48'd0, 1);
    xfer(ebf_pkg::CMD_PRIORITY, 16'h0010,    1, 48'd5, 48'd10, 1);
    xfer(ebf_pkg::CMD_BACKFILL, 16'h0030,    0, TMAX,  TMAX,  1);
    xfer(ebf_pkg::CMD_BACKFILL, 16'h0031,    1, 48'd10, 48'd5, 1);
    xfer(ebf_pkg::CMD_FINISH,   16'h0021,    0, 48'd0, 48'd60, 0);
    xfer(ebf_pkg::CMD_FINISH,   16'h0021,    0, 48'd0, 48'd60, 0);
    xfer(ebf_pkg::CMD_PRIORITY, 16'h0010,    0, 48'd5, 48'd60, 1);
    xfer(ebf_pkg::CMD_PRIORITY, 16'h0040,   64, TMAX,  48'd70, 1);
    xfer(ebf_pkg::CMD_FINISH,   16'h0020,    0, 48'd0, 48'd80, 0);
    xfer(ebf_pkg::CMD_FINISH,   16'h0030,    0, 48'd0, 48'd80, 0);
    xfer(ebf_pkg::CMD_FINISH,   16'h0031,    0, 48'd0, 48'd80, 0);
    xfer(ebf_pkg::CMD_FINISH,   16'h0010,    0, 48'd0, 48'd80, 0);
    xfer(ebf_pkg::CMD_PRIORITY, 16'h0040,    0, 48'd1, TMAX,  1);
    xfer(ebf_pkg::CMD_FINISH,   16'h0040,    0, 48'd0, 48'd90, 0);
    random_phase(300, 0);
    set_total(1);
    random_phase(250, 0);
    set_total(1024);
    random_phase(300, 0);
    set_total(16);
    random_phase(200, 1);
    random_phase(150, 0);
    set_total($urandom_range(1, 1024));
    random_phase(300, 0);
    set_total(64);
    random_phase(150, 0);
    cmd_if.valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2 * NRUN + 16) @(posedge clk_i);
    $display("covered %0d command transfers, %0d results checked, register at 1/16/64/1024",
             sent, checked);
    if (fails == 0) $display("tb_easy_backfill_admission_unit: PASS");
    else $display("tb_easy_backfill_admission_unit: FAIL");
    $finish;
  end
endmodule
